// ----- src/firfc_pkg.sv -----
// firfc_pkg: shared constants, payload types and controller/datapath
// command and status structs for the full-convolution FIR block.
// No dependencies.
`default_nettype none

package firfc_pkg;

  localparam int TAPS  = 32;
  localparam int TAP_W = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int TC_W  = 6;
  localparam int IDX_W = 5;
  localparam int SMP_W = 16;
  localparam int PRD_W = 2 * SMP_W;
  localparam int ACC_W = 40;
  localparam int FRAC  = 15;

  localparam logic [TC_W-1:0] TAP_COUNT_RST = TC_W'(32);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic signed [SMP_W-1:0] sample_t;

  typedef struct packed {
    logic             load_coef;
    logic             shift;
    logic             shift_zero;
    logic             clear_dl;
    logic             clear_acc;
    logic             mul_en;
    logic             out_load;
    logic             out_last;
    logic [TAP_W-1:0] tap_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/firfc_if.sv -----
// firfc_if: valid/ready channel interfaces for input items and result items.
// Depends on firfc_pkg.
`default_nettype none

interface firfc_in_if;
  import firfc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [IDX_W-1:0]       tap_index;
  sample_t                value;
  logic                   last_sample;

  modport source (output valid, cmd, tap_index, value, last_sample, input ready);
  modport sink   (input valid, cmd, tap_index, value, last_sample, output ready);
endinterface

interface firfc_out_if;
  import firfc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_sample;
  logic    saturated;
  logic    last_out;

  modport source (output valid, out_sample, saturated, last_out, input ready);
  modport sink   (input valid, out_sample, saturated, last_out, output ready);
endinterface

`default_nettype wire

// ----- src/fir_full_convolution_top.sv -----
// fir_full_convolution_top: top level joining the controller and datapath.
// Depends on firfc_pkg, firfc_if, firfc_ctrl and firfc_datapath.
`default_nettype none

// A load item (cmd 0) writes one Q1.15 tap. A sample item (cmd 1) shifts
// into the delay line and gives one output after one pass of the single
// shared 16x16 multiply-accumulate over the active taps. Let n be tap_count
// held to the range 1 to 32. After a sample, the next item is taken once
// S_MAC and S_ADD are done and the result register is free. A sample with
// last_sample set adds n - 1 tail outputs, then clears the delay line.
// The final output carries last_out. Each output waits while the result
// register is still held by the sink. Outputs are rounded half up to Q1.15
// and saturated with a flag. A finished output waits in the result register
// without stalling a following load item. tap_count (reset 32) is written
// via cfg_we/cfg_wdata; the user must do it only while idle (not enforced).
module fir_full_convolution_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  firfc_in_if.sink                        samples,
  firfc_out_if.source                     results,
  input  wire logic                       cfg_we,
  input  wire logic [firfc_pkg::TC_W-1:0] cfg_wdata
);
  import firfc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign samples.ready = in_ready;

  firfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_cmd    (samples.cmd),
    .in_last   (samples.last_sample),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  firfc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .tap_index (samples.tap_index),
    .value     (samples.value),
    .results   (results)
  );

endmodule

`default_nettype wire

// ----- src/firfc_ctrl.sv -----
// firfc_ctrl: sequencer for coefficient loads, per-output MAC passes and
// tail generation; holds the tap_count register. Depends on firfc_pkg.
`default_nettype none

module firfc_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_cmd,
  input  wire logic                     in_last,
  output logic                          in_ready,
  input  wire logic                     cfg_we,
  input  wire logic [firfc_pkg::TC_W-1:0] cfg_wdata,
  output firfc_pkg::dp_cmd_t            cmd,
  input  wire firfc_pkg::dp_stat_t      stat
);
  import firfc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state, state_next;
  logic [TC_W-1:0]  tap_count;
  logic [CNT_W-1:0] act;
  logic [TAP_W-1:0] tap, tap_next;
  logic [TAP_W-1:0] tail, tail_next;
  logic             run_last, run_last_next;

  always_comb begin
    if (tap_count == '0) begin
      act = CNT_W'(1);
    end else if (int'(tap_count) > TAPS) begin
      act = CNT_W'(TAPS);
    end else begin
      act = CNT_W'(tap_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_count <= TAP_COUNT_RST;
      tap       <= '0;
      tail      <= '0;
      run_last  <= 1'b0;
    end else begin
      state    <= state_next;
      tap      <= tap_next;
      tail     <= tail_next;
      run_last <= run_last_next;
      if (cfg_we) begin
        tap_count <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next    = state;
    tap_next      = tap;
    tail_next     = tail;
    run_last_next = run_last;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.tap_sel   = tap;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_SAMPLE) begin
            cmd.shift     = 1'b1;
            cmd.clear_acc = 1'b1;
            tap_next      = '0;
            run_last_next = in_last;
            tail_next     = in_last ? TAP_W'(act - CNT_W'(1)) : '0;
            state_next    = S_MAC;
          end else begin
            cmd.load_coef = 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.mul_en = 1'b1;
        tap_next   = tap + TAP_W'(1);
        if (CNT_W'(tap) == act - CNT_W'(1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = run_last && (tail == '0);
          if (tail != '0) begin
            cmd.shift      = 1'b1;
            cmd.shift_zero = 1'b1;
            cmd.clear_acc  = 1'b1;
            tail_next      = tail - TAP_W'(1);
            tap_next       = '0;
            state_next     = S_MAC;
          end else begin
            cmd.clear_dl = run_last;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/firfc_datapath.sv -----
// firfc_datapath: coefficient store, delay line, shared multiplier,
// 40-bit accumulator, round/saturate and result register.
// Depends on firfc_pkg and firfc_if.
`default_nettype none

module firfc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire firfc_pkg::dp_cmd_t          cmd,
  output firfc_pkg::dp_stat_t              stat,
  input  wire logic [firfc_pkg::IDX_W-1:0] tap_index,
  input  wire firfc_pkg::sample_t          value,
  firfc_out_if.source                      results
);
  import firfc_pkg::*;

  sample_t                   coef [TAPS];
  sample_t                   dl   [TAPS];
  logic signed [PRD_W-1:0]   prod;
  logic                      prod_vld;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   rnd;
  logic                      sat;
  sample_t                   res;
  logic                      out_valid;

  assign stat.out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        coef[i] <= '0;
      end
    end else if (cmd.load_coef && (int'(tap_index) < TAPS)) begin
      coef[TAP_W'(tap_index)] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_dl) begin
      for (int i = 0; i < TAPS; i++) begin
        dl[i] <= '0;
      end
    end else if (cmd.shift) begin
      dl[0] <= cmd.shift_zero ? sample_t'(0) : value;
      for (int i = 1; i < TAPS; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= coef[cmd.tap_sel] * dl[cmd.tap_sel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      acc      <= '0;
    end else begin
      prod_vld <= cmd.mul_en;
      if (cmd.clear_acc) begin
        acc <= '0;
      end else if (prod_vld) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  always_comb begin
    rnd = acc + ACC_W'(1 << (FRAC - 1));
    sat = !((&rnd[ACC_W-1:FRAC+SMP_W-1]) || !(|rnd[ACC_W-1:FRAC+SMP_W-1]));
    if (sat) begin
      res = rnd[ACC_W-1] ? sample_t'(-32768) : sample_t'(32767);
    end else begin
      res = rnd[FRAC+SMP_W-1:FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      results.out_sample <= res;
      results.saturated  <= sat;
      results.last_out   <= cmd.out_last;
    end
  end

  assign results.valid = out_valid;

endmodule

`default_nettype wire

// ----- src/firfc_checker.sv -----
// firfc_checker: port-level assertions for fir_full_convolution_top,
// attached by bind. Depends on firfc_pkg and the top level.
`default_nettype none

module firfc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_cmd,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire firfc_pkg::sample_t         out_sample,
  input wire logic                       out_sat,
  input wire logic                       out_last
);
  import firfc_pkg::*;

  logic smp_acc;
  assign smp_acc = in_valid && in_ready && (in_cmd == CMD_SAMPLE);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_sat) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> !in_ready)
    else $error("input taken during a MAC pass");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> !$rose(out_valid))
    else $error("result appeared before the MAC pass finished");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && out_last |-> in_ready)
    else $error("not idle after final output of a run");

endmodule

bind fir_full_convolution_top firfc_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_cmd     (samples.cmd),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_sample (results.out_sample),
  .out_sat    (results.saturated),
  .out_last   (results.last_out)
);

`default_nettype wire
